>>> rtl/romap_pkg.sv
// ----------------------------------------------------------------------------
// romap_pkg
// shared constants, token type and controller states of the range offset map
// ----------------------------------------------------------------------------
package romap_pkg;

  localparam int TABLE_DEPTH = 256;
  localparam int IDX_W       = 8;
  localparam int ADDR_W      = 32;
  localparam int CNT_W       = 9;

  // item kinds carried on the input tuser bit
  localparam logic CMD_LOAD      = 1'b0;
  localparam logic CMD_TRANSLATE = 1'b1;

  // search token handed from cell to cell
  typedef struct packed {
    logic              valid;
    logic              stop;
    logic [ADDR_W-1:0] cand_src;
    logic [ADDR_W-1:0] cand_dst;
  } tok_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DONE
  } state_e;

endpackage

>>> rtl/romap_cell.sv
// ----------------------------------------------------------------------------
// romap_cell
// one map entry plus one stage of the search token chain
// ----------------------------------------------------------------------------
module romap_cell import romap_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              wr_en_i,
  input  logic [ADDR_W-1:0] wr_src_i,
  input  logic [ADDR_W-1:0] wr_dst_i,
  input  logic              in_range_i,
  input  logic [ADDR_W-1:0] addr_i,
  input  tok_t              tok_i,
  output tok_t              tok_o
);

  logic [ADDR_W-1:0] src_q;
  logic [ADDR_W-1:0] dst_q;
  tok_t              tok_d;
  logic              tok_valid_q;
  logic              tok_stop_q;
  logic [ADDR_W-1:0] cand_src_q;
  logic [ADDR_W-1:0] cand_dst_q;

  // entry storage, undefined until loaded
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      src_q <= wr_src_i;
      dst_q <= wr_dst_i;
    end
  end

  always_comb begin
    tok_d = tok_i;
    if (tok_i.valid && in_range_i && !tok_i.stop) begin
      if (src_q > addr_i) begin
        tok_d.stop = 1'b1;
      end else begin
        tok_d.cand_src = src_q;
        tok_d.cand_dst = dst_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_valid_q <= 1'b0;
    end else begin
      tok_valid_q <= tok_d.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    tok_stop_q <= tok_d.stop;
    cand_src_q <= tok_d.cand_src;
    cand_dst_q <= tok_d.cand_dst;
  end

  assign tok_o = {tok_valid_q, tok_stop_q, cand_src_q, cand_dst_q};

endmodule

>>> rtl/range_offset_address_map.sv
// ----------------------------------------------------------------------------
// range_offset_address_map
// translates an address through a table of (source start, target start) pairs
// ----------------------------------------------------------------------------
// load item: written straight into its cell when accepted, no result
// translate item: token walks all TABLE_DEPTH cells, one cell per cycle, so the
//   result is registered after the token leaves the last cell; one item at a time:
//   a new item is taken only once the last result has moved to the output register
// reset: controller idle, output empty, entries_in_use zero; map entries
//   are not cleared and hold garbage until loaded
module range_offset_address_map import romap_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  // configuration write channel: entries_in_use
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [CNT_W-1:0]         cfg_data_i,
  // input items
  input  logic                     s_axis_tvalid,
  output logic                     s_axis_tready,
  // tdata, low bit up: entry_index[7:0], entry_source[31:0],
  //   entry_target[31:0], query_address[31:0]
  input  logic [IDX_W+3*ADDR_W-1:0] s_axis_tdata,
  // tuser: cmd (0 load, 1 translate)
  input  logic                     s_axis_tuser,
  // result items
  output logic                     m_axis_tvalid,
  input  logic                     m_axis_tready,
  // tdata: mapped_address[31:0]
  output logic [ADDR_W-1:0]        m_axis_tdata,
  // tuser: unmapped
  output logic                     m_axis_tuser
);

  // input field unpacking
  logic [IDX_W-1:0]  in_idx;
  logic [ADDR_W-1:0] in_src;
  logic [ADDR_W-1:0] in_dst;
  logic [ADDR_W-1:0] in_addr;

  assign in_idx  = s_axis_tdata[IDX_W-1:0];
  assign in_src  = s_axis_tdata[IDX_W+ADDR_W-1:IDX_W];
  assign in_dst  = s_axis_tdata[IDX_W+2*ADDR_W-1:IDX_W+ADDR_W];
  assign in_addr = s_axis_tdata[IDX_W+3*ADDR_W-1:IDX_W+2*ADDR_W];

  // controller
  state_e state_q, state_d;
  logic   in_acc;
  logic   load_acc;
  logic   xlate_acc;
  logic   res_take;
  logic   launch_q;

  // configuration register, only written while idle
  logic [CNT_W-1:0] entries_q;

  assign cfg_ready_o = (state_q == S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entries_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      entries_q <= cfg_data_i;
    end
  end

  logic [ADDR_W-1:0] addr_q;
  logic [ADDR_W-1:0] res_addr_q, res_addr_d;
  logic              res_unm_q, res_unm_d;
  logic              out_valid_q;
  logic [ADDR_W-1:0] out_data_q;
  logic              out_user_q;

  tok_t tok [TABLE_DEPTH+1];
  tok_t tail;

  assign s_axis_tready = (state_q == S_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign load_acc      = in_acc && (s_axis_tuser == CMD_LOAD);
  assign xlate_acc     = in_acc && (s_axis_tuser == CMD_TRANSLATE);
  assign tail          = tok[TABLE_DEPTH];

  // result can move into the output register when it is empty or draining
  assign res_take = (state_q == S_DONE) && (!out_valid_q || m_axis_tready);

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (xlate_acc) begin
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        if (tail.valid) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (res_take) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // query address is held for the whole walk and broadcast to every cell
  always_ff @(posedge clk_i) begin
    if (xlate_acc) begin
      addr_q <= in_addr;
    end
  end

  // token enters the first cell in the cycle after accept, once addr_q holds the query
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      launch_q <= 1'b0;
    end else begin
      launch_q <= xlate_acc;
    end
  end

  // head token
  always_comb begin
    tok[0].valid    = launch_q;
    tok[0].stop     = 1'b0;
    tok[0].cand_src = '0;
    tok[0].cand_dst = '0;
  end

  // the cell row: cell i holds entry i and looks at the token on its turn
  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    logic wr_en;
    logic in_range;

    assign wr_en    = load_acc && (int'(in_idx) == i);
    assign in_range = (i < int'(entries_q));

    romap_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .wr_en_i    (wr_en),
      .wr_src_i   (in_src),
      .wr_dst_i   (in_dst),
      .in_range_i (in_range),
      .addr_i     (addr_q),
      .tok_i      (tok[i]),
      .tok_o      (tok[i+1])
    );
  end

  // result once the token leaves the last cell: pass-through, unmapped or offset add
  always_comb begin
    res_addr_d = res_addr_q;
    res_unm_d  = res_unm_q;
    if (tail.valid) begin
      if (entries_q == '0) begin
        // empty table passes the address through
        res_addr_d = addr_q;
        res_unm_d  = 1'b0;
      end else if (tail.cand_dst == '0) begin
        res_addr_d = '0;
        res_unm_d  = 1'b1;
      end else begin
        res_addr_d = addr_q - tail.cand_src + tail.cand_dst;
        res_unm_d  = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    res_addr_q <= res_addr_d;
    res_unm_q  <= res_unm_d;
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_take) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_take) begin
      out_data_q <= res_addr_q;
      out_user_q <= res_unm_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;

`ifndef ASSERT_OFF
  a_xlate_starts_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    xlate_acc |=> (state_q == S_SCAN))
    else $error("translate accept did not start a scan");

  a_tail_only_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tail.valid |-> (state_q == S_SCAN))
    else $error("token left the chain outside a scan");

  a_tail_to_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tail.valid |=> (state_q == S_DONE))
    else $error("finished token did not move the controller to done");

  a_unmapped_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata == '0))
    else $error("unmapped result with nonzero address");
`endif

endmodule

>>> sim/range_offset_address_map_test.sv
// ----------------------------------------------------------------------------
// range_offset_address_map_test
// self-checking bench for the range offset address map: stream items in,
// translated addresses out, each compared against a local table mirror
// ----------------------------------------------------------------------------
module range_offset_address_map_test;
  import romap_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // run bounds
  localparam int CYCLE_LIMIT  = 1_000_000;
  // a translate item walks the whole cell chain, so allow a full walk plus slack
  localparam int DRAIN_CYCLES = TABLE_DEPTH + 16;
  localparam int HOLD_CYCLES  = 1500;
  localparam int PHASE_ITEMS  = 70;
  localparam int RANDOM_PHASES = 8;

  // one input item, fields as the block sees them
  typedef struct packed {
    logic              cmd;
    logic [IDX_W-1:0]  idx;
    logic [ADDR_W-1:0] src;
    logic [ADDR_W-1:0] dst;
    logic [ADDR_W-1:0] addr;
  } map_item_t;

  // one translated result
  typedef struct packed {
    logic [ADDR_W-1:0] mapped;
    logic              unmapped;
  } xlat_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic                      cfg_valid_i   = 1'b0;
  logic                      cfg_ready_o;
  logic [CNT_W-1:0]          cfg_data_i    = '0;
  logic                      s_axis_tvalid = 1'b0;
  logic                      s_axis_tready;
  // tdata, low bit up: entry_index, entry_source, entry_target, query_address
  logic [IDX_W+3*ADDR_W-1:0] s_axis_tdata  = '0;
  // tuser: cmd
  logic                      s_axis_tuser  = 1'b0;
  logic                      m_axis_tvalid;
  logic                      m_axis_tready = 1'b0;
  // tdata: mapped_address
  logic [ADDR_W-1:0]         m_axis_tdata;
  // tuser: unmapped
  logic                      m_axis_tuser;

  // mirror of the block's table and entry count
  logic [ADDR_W-1:0] shadow_src [TABLE_DEPTH];
  logic [ADDR_W-1:0] shadow_dst [TABLE_DEPTH];
  logic [CNT_W-1:0]  shadow_count = '0;

  // translations accepted but not yet seen at the output, oldest first
  xlat_t pending_xlat_q [$];

  int  mismatch_count = 0;
  int  cycle_count    = 0;
  int  hold_left      = 0;
  bit  idle_on        = 1'b1;

  range_offset_address_map u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  // 4 ns clock
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("Mismatches found");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // predictor: walk entries below the count, stop at the first source above the
  // address and keep the last entry before it, whose source does not exceed the address
  // ---------------------------------------------------------------------------
  function automatic xlat_t xlat_predict(input logic [ADDR_W-1:0] addr);
    int                n;
    logic [ADDR_W-1:0] cand_src;
    logic [ADDR_W-1:0] cand_dst;
    xlat_t             r;
    // counts above the depth search the whole table
    n = (shadow_count > TABLE_DEPTH) ? TABLE_DEPTH : int'(shadow_count);
    if (n == 0) begin
      // empty table: address passes through, never flagged
      r.mapped   = addr;
      r.unmapped = 1'b0;
      return r;
    end
    // no preceding entry leaves a zero candidate
    cand_src = '0;
    cand_dst = '0;
    for (int i = 0; i < n; i++) begin
      if (shadow_src[i] > addr) break;
      cand_src = shadow_src[i];
      cand_dst = shadow_dst[i];
    end
    if (cand_dst == '0) begin
      r.mapped   = '0;
      r.unmapped = 1'b1;
    end else begin
      // offset sum wraps modulo 2^32
      r.mapped   = addr - cand_src + cand_dst;
      r.unmapped = 1'b0;
    end
    return r;
  endfunction

  // item builders; fields the command ignores carry random filler
  function automatic map_item_t make_load(input logic [IDX_W-1:0] idx,
                                          input logic [ADDR_W-1:0] src,
                                          input logic [ADDR_W-1:0] dst);
    map_item_t it;
    it.cmd  = CMD_LOAD;
    it.idx  = idx;
    it.src  = src;
    it.dst  = dst;
    it.addr = $urandom;
    return it;
  endfunction

  function automatic map_item_t make_xlat(input logic [ADDR_W-1:0] addr);
    map_item_t it;
    it.cmd  = CMD_TRANSLATE;
    it.idx  = IDX_W'($urandom);
    it.src  = $urandom;
    it.dst  = $urandom;
    it.addr = addr;
    return it;
  endfunction

  // ---------------------------------------------------------------------------
  // sender: random gaps while idling is on, valid held until accepted, mirror updated on accept
  // ---------------------------------------------------------------------------
  task automatic send_item(input map_item_t it);
    @(negedge clk_i);
    while (idle_on && $urandom_range(99) < 34) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tuser  = it.cmd;
    s_axis_tdata  = {it.addr, it.dst, it.src, it.idx};
    do @(posedge clk_i); while (!s_axis_tready);
    // config only moves while idle, so predicting at accept is safe
    if (it.cmd == CMD_LOAD) begin
      shadow_src[it.idx] = it.src;
      shadow_dst[it.idx] = it.dst;
    end else begin
      pending_xlat_q.push_back(xlat_predict(it.addr));
    end
  endtask

  // drop valid and wait until every result is back and the last load is done
  task automatic wait_idle();
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    while (pending_xlat_q.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  // entry count write, only from idle
  task automatic write_entry_count(input logic [CNT_W-1:0] value);
    wait_idle();
    cfg_valid_i = 1'b1;
    cfg_data_i  = value;
    do @(posedge clk_i); while (!cfg_ready_o);
    shadow_count = value;
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // receiver: random stalls while idling is on, plus a counted hold-off when asked for
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready = 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      m_axis_tready = 1'b0;
    end else if (idle_on && $urandom_range(99) < 34) begin
      m_axis_tready = 1'b0;
    end else begin
      m_axis_tready = 1'b1;
    end
  end

  // result check against the oldest pending translation
  always @(posedge clk_i) begin : result_check
    xlat_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_xlat_q.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("%0t: unexpected result mapped %h unmapped %b, none pending",
                   $realtime, m_axis_tdata, m_axis_tuser);
      end else begin
        want = pending_xlat_q.pop_front();
        if (m_axis_tdata !== want.mapped || m_axis_tuser !== want.unmapped) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("%0t: mapped %h unmapped %b, expected mapped %h unmapped %b",
                     $realtime, m_axis_tdata, m_axis_tuser, want.mapped,
                     want.unmapped);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // zero count: addresses come back unchanged, table never read
  task automatic test_pass_through();
    write_entry_count('0);
    send_item(make_xlat(32'h0000_0000));
    send_item(make_xlat(32'hFFFF_FFFF));
    send_item(make_xlat(32'hA5A5_A5A5));
  endtask

  // four-entry table covering each lookup corner
  task automatic test_small_table();
    send_item(make_load(8'd0, 32'h0000_1000, 32'h0000_8000));
    // zero target marks an unmapped range
    send_item(make_load(8'd1, 32'h0000_2000, 32'h0000_0000));
    // target near the top so the offset sum wraps
    send_item(make_load(8'd2, 32'h0000_3000, 32'hFFFF_FFF0));
    send_item(make_load(8'd3, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    // top slot, outside the searched range
    send_item(make_load(8'd255, 32'h0000_0000, 32'h1234_5678));
    write_entry_count(9'd4);
    send_item(make_xlat(32'h0000_0FFF));  // below the first source
    send_item(make_xlat(32'h0000_1000));  // exactly on a source
    send_item(make_xlat(32'h0000_1FFF));  // last address of a range
    send_item(make_xlat(32'h0000_2000));  // unmapped range
    send_item(make_xlat(32'h0000_3020));  // wrapping sum
    send_item(make_xlat(32'hFFFF_FFFF));  // top address on the last entry
    send_item(make_xlat(32'h0000_0000));
  endtask

  // output held off long enough that the block fills and stalls its input
  task automatic test_output_backpressure();
    @(posedge clk_i);
    hold_left = HOLD_CYCLES;
    repeat (6) send_item(make_xlat($urandom_range(32'h0000_3FFF, 32'h0000_0F00)));
  endtask

  // full table with ordered sources, then mixed traffic over several counts
  task automatic test_random_traffic();
    logic [63:0]       acc;
    logic [CNT_W-1:0]  count;
    logic [ADDR_W-1:0] lo;
    logic [ADDR_W-1:0] hi;
    logic [ADDR_W-1:0] addr;
    logic [ADDR_W-1:0] dst;
    int                n;
    int                i;
    int                pick;
    // fill every slot so any count reads loaded entries only
    acc = ($urandom_range(3) == 0) ? 64'd0 : 64'($urandom_range(32'hFFFF, 0));
    for (int k = 0; k < TABLE_DEPTH; k++) begin
      if (k > 0) acc += 64'($urandom_range(32'h00FF_0000, 1));
      dst = ($urandom_range(7) == 0) ? '0 : $urandom;
      send_item(make_load(k[IDX_W-1:0], acc[ADDR_W-1:0], dst));
    end
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      case (phase)
        0: count = 9'(TABLE_DEPTH);
        1: count = '1;                          // largest count the register holds
        2: count = 9'd1;
        3: count = 9'(TABLE_DEPTH + 1);
        default: count = 9'($urandom_range(511, 0));
      endcase
      // one phase with neither side idling
      idle_on = (phase != 4);
      write_entry_count(count);
      n = (shadow_count > TABLE_DEPTH) ? TABLE_DEPTH : int'(shadow_count);
      repeat (PHASE_ITEMS) begin
        pick = $urandom_range(99);
        if (pick < 15) begin
          // reload a slot; mostly keeps sources in order, sometimes noise
          i   = $urandom_range(TABLE_DEPTH - 1);
          dst = ($urandom_range(7) == 0) ? '0 : $urandom;
          lo  = (i == 0) ? '0 : shadow_src[i-1];
          hi  = (i == TABLE_DEPTH - 1) ? '1 : shadow_src[i+1];
          if (pick < 10)
            send_item(make_load(i[IDX_W-1:0], $urandom_range(hi, lo), dst));
          else
            send_item(make_load(i[IDX_W-1:0], $urandom, dst));
        end else begin
          pick = $urandom_range(99);
          i    = (n > 0) ? $urandom_range(n - 1) : 0;
          if (n > 0 && pick < 60)
            addr = shadow_src[i] + $urandom_range(4095);  // inside a range
          else if (n > 0 && pick < 70)
            addr = shadow_src[i];                         // on a boundary
          else if (n > 0 && pick < 80)
            addr = shadow_src[i] - 1;                     // just before one
          else if (pick < 92)
            addr = $urandom;
          else
            addr = ($urandom_range(1) == 0) ? '0 : '1;
          send_item(make_xlat(addr));
        end
      end
    end
    idle_on = 1'b1;
  endtask

  // ---------------------------------------------------------------------------
  // sequence
  // ---------------------------------------------------------------------------
  initial begin
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_pass_through();
    test_small_table();
    test_output_backpressure();
    test_random_traffic();

    // drain, then give the block one more full walk to misbehave in
    wait_idle();
    if (pending_xlat_q.size() != 0) mismatch_count++;
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
